// File: sv/srf_pkg.sv
// Shared types and constants of the special register file block.
// Used by srf_shadow_mem, srf_named_regs and special_register_file_access.
`default_nettype none

package srf_pkg;

  localparam int DATA_W = 32;
  localparam int SPR_W  = 12;
  localparam int OP_W   = 2;
  localparam int TB_W   = 64;

  localparam int SHADOW_DEPTH_DEF = 2048;

  localparam logic [DATA_W-1:0] PVR_RESET = 32'h0008_7200;

  // Operation codes of an input item.
  localparam logic [OP_W-1:0] OP_READ  = 2'd0;
  localparam logic [OP_W-1:0] OP_WRITE = 2'd1;
  localparam logic [OP_W-1:0] OP_TICK  = 2'd2;

  // Register numbers with a fixed meaning.
  localparam logic [SPR_W-1:0] N_XER     = 12'd1;
  localparam logic [SPR_W-1:0] N_LR      = 12'd8;
  localparam logic [SPR_W-1:0] N_CTR     = 12'd9;
  localparam logic [SPR_W-1:0] N_SRR0    = 12'd26;
  localparam logic [SPR_W-1:0] N_SRR1    = 12'd27;
  localparam logic [SPR_W-1:0] N_TBL     = 12'd268;
  localparam logic [SPR_W-1:0] N_TBU     = 12'd269;
  localparam logic [SPR_W-1:0] N_PVR     = 12'd287;
  localparam logic [SPR_W-1:0] N_QR_LO   = 12'd912;
  localparam logic [SPR_W-1:0] N_QR_HI   = 12'd919;
  localparam logic [SPR_W-1:0] N_IMPL2   = 12'd920;
  localparam logic [SPR_W-1:0] N_IMPL0   = 12'd1008;
  localparam logic [SPR_W-1:0] N_IMPL1   = 12'd1009;

  // Configuration register index, taken from the word address bit.
  localparam logic CFG_IDX_PVR = 1'b0;

  typedef struct packed {
    logic              vld;
    logic [OP_W-1:0]   op;
    logic [SPR_W-1:0]  num;
    logic [DATA_W-1:0] data;
  } srf_req_t;

  typedef struct packed {
    logic              slot;  // number names a writable register
    logic              hit;   // number is served by the named registers on a read
    logic [DATA_W-1:0] data;
  } srf_named_rsp_t;

endpackage

`default_nettype wire

// File: sv/special_register_file_access.sv
// Top level of the special register file: request register, named registers,
// shadow store and result register. Uses srf_pkg, srf_named_regs, srf_shadow_mem.
//
//   channel  | ports                                        | transfer
//   ---------+----------------------------------------------+---------------------------
//   input    | start, busy, in_opcode/spr_number/write_data | start high, busy low
//   result   | out_strobe, out_read_data                    | out_strobe high, one cycle
//   config   | psel, penable, pwrite, paddr, pwdata, prdata | psel, penable, pwrite, pready
//
// One item is taken per cycle while busy is low. A read result passes through
// the request register, then through the result register and the shadow
// store's read register. After reset busy stays high while the shadow store
// is swept to zero, one word a cycle; configuration writes are taken during
// that time. Results cannot be stalled and the block never holds off the
// input once the sweep is done.
`default_nettype none

module special_register_file_access
  import srf_pkg::*;
#(
  parameter int SHADOW_DEPTH = SHADOW_DEPTH_DEF
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              start,
  output logic                   busy,
  input  wire logic [OP_W-1:0]   in_opcode,
  input  wire logic [SPR_W-1:0]  in_spr_number,
  input  wire logic [DATA_W-1:0] in_write_data,
  output logic                   out_strobe,
  output logic [DATA_W-1:0]      out_read_data,
  input  wire logic              psel,
  input  wire logic              penable,
  input  wire logic              pwrite,
  input  wire logic [2:0]        paddr,
  input  wire logic [DATA_W-1:0] pwdata,
  output logic [DATA_W-1:0]      prdata,
  output logic                   pready
);

  localparam int AW = $clog2(SHADOW_DEPTH);

  srf_req_t          req_r, req_nxt;
  srf_named_rsp_t    named_rsp;
  logic [DATA_W-1:0] pvr_r;
  logic              accept;
  logic              clearing;
  logic              in_range;
  logic              shadow_we;
  logic [DATA_W-1:0] mem_q;

  logic              out_strobe_r;
  logic              use_named_r;
  logic              in_range_r;
  logic [DATA_W-1:0] named_val_r;

  // Configuration port
  assign pready = 1'b1;
  assign prdata = (paddr[2] == CFG_IDX_PVR) ? pvr_r : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pvr_r <= PVR_RESET;
    end else if (psel && penable && pwrite && pready && (paddr[2] == CFG_IDX_PVR)) begin
      pvr_r <= pwdata;
    end
  end

  // Request register
  assign busy   = clearing;
  assign accept = start && !busy;

  always_comb begin
    req_nxt      = req_r;
    req_nxt.vld  = accept;
    if (accept) begin
      req_nxt.op   = in_opcode;
      req_nxt.num  = in_spr_number;
      req_nxt.data = in_write_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      req_r.vld <= 1'b0;
    end else begin
      req_r.vld <= req_nxt.vld;
    end
    req_r.op   <= req_nxt.op;
    req_r.num  <= req_nxt.num;
    req_r.data <= req_nxt.data;
  end

  srf_named_regs u_named (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (req_r),
    .pvr   (pvr_r),
    .rsp   (named_rsp)
  );

  // Numbers at or above the store depth read zero and drop writes.
  assign in_range  = {1'b0, req_r.num} < (SPR_W + 1)'(SHADOW_DEPTH);
  assign shadow_we = req_r.vld && (req_r.op == OP_WRITE) && !named_rsp.slot && in_range;

  srf_shadow_mem #(
    .SHADOW_DEPTH (SHADOW_DEPTH)
  ) u_shadow (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_en    (shadow_we),
    .wr_addr  (req_r.num[AW-1:0]),
    .wr_data  (req_r.data),
    .rd_addr  (req_r.num[AW-1:0]),
    .rd_data  (mem_q),
    .clearing (clearing)
  );

  // Result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_strobe_r <= 1'b0;
    end else begin
      out_strobe_r <= req_r.vld && (req_r.op == OP_READ);
    end
    use_named_r <= named_rsp.hit;
    in_range_r  <= in_range;
    named_val_r <= named_rsp.data;
  end

  assign out_strobe    = out_strobe_r;
  assign out_read_data = use_named_r ? named_val_r : (in_range_r ? mem_q : '0);

  a_strobe_from_read: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |-> $past(rst_n && start && !busy && in_opcode == OP_READ, 2))
    else $error("result strobe without a read transfer two cycles earlier");

  a_sweep_once: assert property (@(posedge clk) disable iff (!rst_n)
    !busy |=> !busy)
    else $error("busy rose again outside reset");

  a_pvr_reset: assert property (@(posedge clk)
    $past(!rst_n) |-> pvr_r == PVR_RESET)
    else $error("version register not at its reset value after reset");

endmodule

`default_nettype wire

// File: sv/srf_shadow_mem.sv
// Shadow store of the special register file: one write and one read port,
// registered read data, and a zeroing sweep after reset. Uses srf_pkg.
`default_nettype none

module srf_shadow_mem
  import srf_pkg::*;
#(
  parameter int SHADOW_DEPTH = SHADOW_DEPTH_DEF,
  localparam int AW = $clog2(SHADOW_DEPTH)
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              wr_en,
  input  wire logic [AW-1:0]     wr_addr,
  input  wire logic [DATA_W-1:0] wr_data,
  input  wire logic [AW-1:0]     rd_addr,
  output logic [DATA_W-1:0]      rd_data,
  output logic                   clearing
);

  localparam logic [AW-1:0] LAST_ADDR = AW'(SHADOW_DEPTH - 1);

  logic [DATA_W-1:0] mem [SHADOW_DEPTH];
  logic [DATA_W-1:0] rd_data_r;
  logic              clearing_r, clearing_nxt;
  logic [AW-1:0]     clr_cnt_r, clr_cnt_nxt;
  logic              we;
  logic [AW-1:0]     wa;
  logic [DATA_W-1:0] wd;

  always_comb begin
    clearing_nxt = clearing_r;
    clr_cnt_nxt  = clr_cnt_r;
    if (clearing_r) begin
      clr_cnt_nxt = clr_cnt_r + AW'(1);
      if (clr_cnt_r == LAST_ADDR) begin
        clearing_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clearing_r <= 1'b1;
      clr_cnt_r  <= '0;
    end else begin
      clearing_r <= clearing_nxt;
      clr_cnt_r  <= clr_cnt_nxt;
    end
  end

  // The sweep owns the write port until every word holds zero.
  assign we = clearing_r | wr_en;
  assign wa = clearing_r ? clr_cnt_r : wr_addr;
  assign wd = clearing_r ? '0 : wr_data;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[wa] <= wd;
    end
    rd_data_r <= mem[rd_addr];
  end

  assign rd_data  = rd_data_r;
  assign clearing = clearing_r;

  a_no_item_write_in_sweep: assert property (@(posedge clk) disable iff (!rst_n)
    clearing_r |-> !wr_en)
    else $error("item write reached the shadow store during the zeroing sweep");

endmodule

`default_nettype wire

// File: sv/srf_named_regs.sv
// Named special registers: quantization, link, count, exception,
// save/restore, implementation registers and the 64-bit time base. Uses srf_pkg.
`default_nettype none

module srf_named_regs
  import srf_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire srf_req_t          req,
  input  wire logic [DATA_W-1:0] pvr,
  output srf_named_rsp_t         rsp
);

  logic [DATA_W-1:0] quant_r [8];
  logic [DATA_W-1:0] impl_r  [3];
  logic [DATA_W-1:0] lr_r, ctr_r, xer_r, srr0_r, srr1_r;
  logic [TB_W-1:0]   tb_r, tb_nxt;

  logic              is_qr;
  logic [2:0]        qidx;
  logic              slot;
  logic [DATA_W-1:0] slot_val;
  logic              wr;

  assign is_qr = (req.num >= N_QR_LO) && (req.num <= N_QR_HI);
  assign qidx  = 3'(req.num - N_QR_LO);

  always_comb begin
    slot     = 1'b1;
    slot_val = '0;
    if (is_qr) begin
      slot_val = quant_r[qidx];
    end else begin
      unique case (req.num)
        N_LR:    slot_val = lr_r;
        N_CTR:   slot_val = ctr_r;
        N_XER:   slot_val = xer_r;
        N_SRR0:  slot_val = srr0_r;
        N_SRR1:  slot_val = srr1_r;
        N_IMPL0: slot_val = impl_r[0];
        N_IMPL1: slot_val = impl_r[1];
        N_IMPL2: slot_val = impl_r[2];
        default: slot = 1'b0;
      endcase
    end
  end

  always_comb begin
    rsp.slot = slot;
    rsp.hit  = 1'b1;
    rsp.data = slot_val;
    if (!slot) begin
      unique case (req.num)
        N_TBL:   rsp.data = tb_r[DATA_W-1:0];
        N_TBU:   rsp.data = tb_r[TB_W-1:DATA_W];
        N_PVR:   rsp.data = pvr;
        default: rsp.hit  = 1'b0;
      endcase
    end
  end

  assign wr     = req.vld && (req.op == OP_WRITE) && slot;
  assign tb_nxt = (req.vld && (req.op == OP_TICK)) ? tb_r + TB_W'(1) : tb_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < 8; i++) begin
        quant_r[i] <= '0;
      end
      for (int i = 0; i < 3; i++) begin
        impl_r[i] <= '0;
      end
      lr_r   <= '0;
      ctr_r  <= '0;
      xer_r  <= '0;
      srr0_r <= '0;
      srr1_r <= '0;
      tb_r   <= '0;
    end else begin
      tb_r <= tb_nxt;
      if (wr) begin
        if (is_qr) begin
          quant_r[qidx] <= req.data;
        end else begin
          unique case (req.num)
            N_LR:    lr_r      <= req.data;
            N_CTR:   ctr_r     <= req.data;
            N_XER:   xer_r     <= req.data;
            N_SRR0:  srr0_r    <= req.data;
            N_SRR1:  srr1_r    <= req.data;
            N_IMPL0: impl_r[0] <= req.data;
            N_IMPL1: impl_r[1] <= req.data;
            N_IMPL2: impl_r[2] <= req.data;
            default: ;
          endcase
        end
      end
    end
  end

  a_tick_advances: assert property (@(posedge clk) disable iff (!rst_n)
    (req.vld && req.op == OP_TICK) |=> tb_r == $past(tb_r) + TB_W'(1))
    else $error("time base did not advance by one on a tick");

  a_tb_holds: assert property (@(posedge clk) disable iff (!rst_n)
    !(req.vld && req.op == OP_TICK) |=> tb_r == $past(tb_r))
    else $error("time base changed without a tick");

endmodule

`default_nettype wire

// File: tb/sv/special_register_file_access_test.sv
// Self-checking testbench for special_register_file_access: reads, writes and ticks
// go in, and every read result is checked against a model of the register file.
// Depends on srf_pkg and the special_register_file_access RTL only.

module special_register_file_access_test;
  import srf_pkg::*;

  localparam int CYCLE_LIMIT = 200000;
  localparam int ITEMS_PER_PHASE = 250;
  localparam int PHASES = 5;
  localparam int SETTLE_CYCLES = 4;

  localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;
  localparam logic [SPR_W-1:0] N_DSISR = 12'd22;
  localparam logic [2:0] PVR_ADDR = {CFG_IDX_PVR, 2'b00};

  localparam int NAMED_COUNT = 14;
  localparam logic [SPR_W-1:0] NAMED_NUMS [NAMED_COUNT] = '{
    N_XER, N_LR, N_CTR, N_DSISR, N_SRR0, N_SRR1, N_TBL, N_TBU, N_PVR,
    N_IMPL0, N_IMPL1, N_IMPL2, N_QR_LO, N_QR_HI
  };

  // Keeps a copy of all architected state and the read values still owed.
  class spr_file_tracker;
    bit [DATA_W-1:0] shadow [SHADOW_DEPTH_DEF];
    bit [DATA_W-1:0] quant [8];
    bit [DATA_W-1:0] link, count, exc, srr0, srr1, version;
    bit [DATA_W-1:0] impl [3];
    bit [TB_W-1:0]   tbase;
    bit [DATA_W-1:0] pending_reads [$];
    int unsigned     fails, reads, writes, ticks, ignored;

    function new();
      foreach (shadow[i]) shadow[i] = '0;
      foreach (quant[i]) quant[i] = '0;
      foreach (impl[i]) impl[i] = '0;
      link = '0;
      count = '0;
      exc = '0;
      srr0 = '0;
      srr1 = '0;
      tbase = '0;
      version = PVR_RESET;
    endfunction

    function bit [DATA_W-1:0] lookup(bit [SPR_W-1:0] num);
      bit [SPR_W-1:0] qidx;
      qidx = num - N_QR_LO;
      if (num >= N_QR_LO && num <= N_QR_HI) return quant[qidx[2:0]];
      case (num)
        N_LR:    return link;
        N_CTR:   return count;
        N_XER:   return exc;
        N_SRR0:  return srr0;
        N_SRR1:  return srr1;
        N_IMPL0: return impl[0];
        N_IMPL1: return impl[1];
        N_IMPL2: return impl[2];
        N_TBL:   return tbase[31:0];
        N_TBU:   return tbase[63:32];
        N_PVR:   return version;
        default: return (num < SHADOW_DEPTH_DEF) ? shadow[num] : '0;
      endcase
    endfunction

    // The time base and version numbers are not writable, so writes there
    // fall through to the shadow store like any unmapped number.
    function void store(bit [SPR_W-1:0] num, bit [DATA_W-1:0] value);
      bit [SPR_W-1:0] qidx;
      qidx = num - N_QR_LO;
      if (num >= N_QR_LO && num <= N_QR_HI) begin
        quant[qidx[2:0]] = value;
        return;
      end
      case (num)
        N_LR:    link = value;
        N_CTR:   count = value;
        N_XER:   exc = value;
        N_SRR0:  srr0 = value;
        N_SRR1:  srr1 = value;
        N_IMPL0: impl[0] = value;
        N_IMPL1: impl[1] = value;
        N_IMPL2: impl[2] = value;
        default: if (num < SHADOW_DEPTH_DEF) shadow[num] = value;
      endcase
    endfunction

    function void take_item(bit [OP_W-1:0] op, bit [SPR_W-1:0] num, bit [DATA_W-1:0] data);
      case (op)
        OP_READ: begin
          pending_reads.push_back(lookup(num));
          reads++;
        end
        OP_WRITE: begin
          store(num, data);
          writes++;
        end
        OP_TICK: begin
          tbase = tbase + 1'b1;
          ticks++;
        end
        default: ignored++;
      endcase
    endfunction

    function void check_read(bit [DATA_W-1:0] actual);
      bit [DATA_W-1:0] expected;
      if (pending_reads.size() == 0) begin
        $display("%0t: read result %h arrived with no read outstanding", $time, actual);
        fails++;
        return;
      end
      expected = pending_reads.pop_front();
      if (actual !== expected) begin
        $display("%0t: read_data mismatch: expected %h, actual %h", $time, expected, actual);
        fails++;
      end
    endfunction
  endclass

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              start = 1'b0;
  logic [OP_W-1:0]   in_opcode = OP_READ;
  logic [SPR_W-1:0]  in_spr_number = '0;
  logic [DATA_W-1:0] in_write_data = '0;
  logic              psel = 1'b0;
  logic              penable = 1'b0;
  logic              pwrite = 1'b0;
  logic [2:0]        paddr = '0;
  logic [DATA_W-1:0] pwdata = '0;
  logic              busy;
  logic              out_strobe;
  logic [DATA_W-1:0] out_read_data;
  logic [DATA_W-1:0] prdata;
  logic              pready;

  spr_file_tracker tracker;
  int cycle_count = 0;
  int version_settings = 1;

  special_register_file_access #(
    .SHADOW_DEPTH(SHADOW_DEPTH_DEF)
  ) u_dut (
    .clk(clk),
    .rst_n(rst_n),
    .start(start),
    .busy(busy),
    .in_opcode(in_opcode),
    .in_spr_number(in_spr_number),
    .in_write_data(in_write_data),
    .out_strobe(out_strobe),
    .out_read_data(out_read_data),
    .psel(psel),
    .penable(penable),
    .pwrite(pwrite),
    .paddr(paddr),
    .pwdata(pwdata),
    .prdata(prdata),
    .pready(pready)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Timed out after %0d cycles", cycle_count);
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  // Results cannot be held off, so every strobe is a completed transfer.
  always @(posedge clk) begin
    if (rst_n && out_strobe) tracker.check_read(out_read_data);
  end

  task automatic send_item(input logic [OP_W-1:0] op, input logic [SPR_W-1:0] num,
                           input logic [DATA_W-1:0] data);
    start <= 1'b1;
    in_opcode <= op;
    in_spr_number <= num;
    in_write_data <= data;
    do @(posedge clk); while (busy);
    tracker.take_item(op, num, data);
  endtask

  // Leaves the input quiet; the payload is given random values to show it is ignored.
  task automatic rest(input int cycles);
    start <= 1'b0;
    in_opcode <= OP_W'($urandom);
    in_spr_number <= SPR_W'($urandom);
    in_write_data <= $urandom;
    repeat (cycles) @(posedge clk);
  endtask

  task automatic drain();
    start <= 1'b0;
    while (tracker.pending_reads.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic set_version(input logic [DATA_W-1:0] value);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= PVR_ADDR;
    pwdata <= value;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    tracker.version = value;
    version_settings++;
  endtask

  function automatic logic [SPR_W-1:0] pick_number();
    int unsigned sel;
    sel = $urandom_range(0, 99);
    if (sel < 35) return NAMED_NUMS[$urandom_range(0, NAMED_COUNT - 1)];
    if (sel < 45) return N_QR_LO + SPR_W'($urandom_range(0, 7));
    if (sel < 62) return SPR_W'($urandom_range(0, 63));
    if (sel < 74) return SPR_W'(SHADOW_DEPTH_DEF - 8 + $urandom_range(0, 15));
    return SPR_W'($urandom);
  endfunction

  function automatic logic [DATA_W-1:0] pick_data();
    case ($urandom_range(0, 5))
      0: return '0;
      1: return '1;
      2: return DATA_W'(1) << $urandom_range(0, DATA_W - 1);
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [OP_W-1:0] pick_op();
    int unsigned sel;
    sel = $urandom_range(0, 99);
    if (sel < 45) return OP_READ;
    if (sel < 85) return OP_WRITE;
    if (sel < 97) return OP_TICK;
    return OP_UNUSED;
  endfunction

  task automatic run_directed();
    send_item(OP_READ, N_PVR, '0);
    send_item(OP_READ, N_TBL, '1);
    send_item(OP_TICK, N_TBL, '1);
    send_item(OP_TICK, '1, '0);
    send_item(OP_READ, N_TBL, '0);
    send_item(OP_READ, N_TBU, '0);
    send_item(OP_WRITE, N_LR, 32'hFFFF_FFFF);
    send_item(OP_WRITE, N_CTR, 32'h8000_0001);
    send_item(OP_WRITE, N_QR_LO, 32'hA5A5_5A5A);
    send_item(OP_WRITE, N_QR_HI, 32'h0000_0001);
    send_item(OP_WRITE, N_IMPL2, 32'h7FFF_FFFE);
    send_item(OP_READ, N_LR, '0);
    send_item(OP_READ, N_CTR, '0);
    send_item(OP_READ, N_QR_LO, '0);
    send_item(OP_READ, N_QR_HI, '0);
    send_item(OP_READ, N_IMPL2, '0);
    // Read-only numbers take writes into the shadow store only.
    send_item(OP_WRITE, N_TBL, 32'hDEAD_BEEF);
    send_item(OP_WRITE, N_PVR, 32'hFFFF_FFFF);
    send_item(OP_READ, N_TBL, '0);
    send_item(OP_READ, N_PVR, '0);
    send_item(OP_WRITE, N_DSISR, 32'h1234_5678);
    send_item(OP_READ, N_DSISR, '0);
    // Numbers past the store's depth drop writes and read zero.
    send_item(OP_WRITE, '1, '1);
    send_item(OP_READ, '1, '0);
    send_item(OP_UNUSED, N_PVR, '1);
  endtask

  task automatic run_random(input int items, input bit quiet);
    bit calm;
    calm = 1'b0;
    for (int i = 0; i < items; i++) begin
      if (i % 40 == 0) calm = $urandom_range(0, 2) == 0;
      send_item(pick_op(), pick_number(), pick_data());
      if (!quiet && !calm && $urandom_range(0, 3) == 0) rest($urandom_range(1, 9));
    end
  endtask

  initial begin
    logic [DATA_W-1:0] settings [PHASES];
    tracker = new();
    settings = '{32'hFFFF_FFFF, 32'h0000_0000, $urandom, 32'h8000_0000, $urandom};
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    run_directed();
    drain();
    for (int p = 0; p < PHASES; p++) begin
      set_version(settings[p]);
      run_random(ITEMS_PER_PHASE, p == PHASES - 1);
      drain();
    end
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (tracker.pending_reads.size() != 0) begin
      $display("%0t: %0d read results never arrived", $time, tracker.pending_reads.size());
      tracker.fails++;
    end
    $display("Ran %0d reads, %0d writes, %0d ticks and %0d unused opcodes",
             tracker.reads, tracker.writes, tracker.ticks, tracker.ignored);
    $display("over %0d version settings; time base ended at %0d", version_settings,
             tracker.tbase);
    if (tracker.fails == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
